>>> design/proof_language_lexer_defines.svh
// Assertion macros shared by the lexer modules.
`ifndef PROOF_LANGUAGE_LEXER_DEFINES_SVH
`define PROOF_LANGUAGE_LEXER_DEFINES_SVH

`ifndef SYNTH
`define PLX_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("lexer assertion failed");
`define PLX_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lexer assertion failed");
`define PLX_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lexer assertion failed");
`else
`define PLX_ASSERT_ALWAYS(label, clk, rst, cond)
`define PLX_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define PLX_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> design/plx_pkg.sv
package plx_pkg;

  localparam int LINE_BITS   = 16;
  localparam int COL_BITS    = 12;
  localparam int KIND_BITS   = 6;
  localparam int CHAR_BITS   = 8;
  localparam int PREFIX_CHARS = 5;
  localparam int PREFIX_BITS = PREFIX_CHARS * CHAR_BITS;
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_BITS    = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS    = $clog2(FIFO_DEPTH + 1);
  localparam int S_DATA_W    = CHAR_BITS;
  localparam int S_USER_W    = 2;
  localparam int M_DATA_W    = ((LINE_BITS + 2 * COL_BITS + 7) / 8) * 8;
  localparam int M_USER_W    = KIND_BITS + 1;

  localparam logic [COL_BITS-1:0] COL_MAX = '1;

  typedef enum logic [1:0] {
    CMD_CHAR,
    CMD_EOL,
    CMD_RESTART,
    CMD_IGNORE
  } cmd_t;

  typedef enum logic [3:0] {
    P_NONE, P_SLASH, P_COLON, P_LT, P_LT_MINUS, P_LT_EQ,
    P_MINUS, P_EQ, P_IDENT, P_NUMBER, P_STAR
  } pend_t;

  typedef enum logic [KIND_BITS-1:0] {
    K_NEWLINE, K_NUMBER, K_CHAR, K_STRING, K_LBRACKET, K_RBRACKET, K_COMMA,
    K_COLON, K_SEMICOLON, K_BACKSLASH, K_PERIOD, K_LPAREN, K_RPAREN,
    K_LBRACE, K_RBRACE, K_DOLLAR, K_QUESTION, K_PERCENT, K_ASTERISK, K_AT,
    K_HASH, K_UNDERSCORE, K_HYPHEN, K_VBAR, K_LARROW, K_RARROW, K_LRARROW,
    K_LDARROW, K_RDARROW, K_LRDARROW, K_DEFBY, K_DEF2, K_EDEF2, K_END
  } kind_t;

  localparam logic [CHAR_BITS-1:0] CH_TAB        = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_SPACE      = " ";
  localparam logic [CHAR_BITS-1:0] CH_SLASH      = "/";
  localparam logic [CHAR_BITS-1:0] CH_STAR       = "*";
  localparam logic [CHAR_BITS-1:0] CH_COLON      = ":";
  localparam logic [CHAR_BITS-1:0] CH_LT         = "<";
  localparam logic [CHAR_BITS-1:0] CH_EQ         = "=";
  localparam logic [CHAR_BITS-1:0] CH_GT         = ">";
  localparam logic [CHAR_BITS-1:0] CH_MINUS      = "-";
  localparam logic [CHAR_BITS-1:0] CH_UNDERSCORE = "_";

  localparam logic [PREFIX_BITS-1:0] ID_END   = 40'h00_0045_4E44;
  localparam logic [PREFIX_BITS-1:0] ID_DEF2  = 40'h00_6465_6632;
  localparam logic [PREFIX_BITS-1:0] ID_EDEF2 = 40'h65_6465_6632;
  localparam logic [COL_BITS-1:0] LEN_END   = COL_BITS'(3);
  localparam logic [COL_BITS-1:0] LEN_DEF2  = COL_BITS'(4);
  localparam logic [COL_BITS-1:0] LEN_EDEF2 = COL_BITS'(5);
  localparam logic [COL_BITS-1:0] LEN_PREFIX = COL_BITS'(PREFIX_CHARS);

  typedef struct packed {
    kind_t                kind;
    logic [LINE_BITS-1:0] line;
    logic [COL_BITS-1:0]  col;
    logic [COL_BITS-1:0]  len;
    logic                 err;
    logic                 last;
  } res_t;

  // Results of one item: up to two, first one in 'first'.
  typedef struct packed {
    res_t       first;
    res_t       second;
    logic [1:0] count;
  } core_out_t;

  typedef struct packed {
    logic  hit;
    kind_t kind;
  } sym_t;

  function automatic logic is_letter(input logic [CHAR_BITS-1:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [COL_BITS-1:0] sat_inc(input logic [COL_BITS-1:0] v);
    return (v == COL_MAX) ? v : v + COL_BITS'(1);
  endfunction

  function automatic sym_t symbol_lookup(input logic [CHAR_BITS-1:0] c);
    sym_t s;
    s.hit  = 1'b1;
    s.kind = K_NEWLINE;
    unique case (c)
      "(":     s.kind = K_LPAREN;
      ")":     s.kind = K_RPAREN;
      "[":     s.kind = K_LBRACKET;
      "]":     s.kind = K_RBRACKET;
      "{":     s.kind = K_LBRACE;
      "}":     s.kind = K_RBRACE;
      "$":     s.kind = K_DOLLAR;
      "?":     s.kind = K_QUESTION;
      "@":     s.kind = K_AT;
      "*":     s.kind = K_ASTERISK;
      ":":     s.kind = K_COLON;
      ".":     s.kind = K_PERIOD;
      ",":     s.kind = K_COMMA;
      "\\":    s.kind = K_BACKSLASH;
      ";":     s.kind = K_SEMICOLON;
      "#":     s.kind = K_HASH;
      "%":     s.kind = K_PERCENT;
      "|":     s.kind = K_VBAR;
      "_":     s.kind = K_UNDERSCORE;
      "-":     s.kind = K_HYPHEN;
      default: s.hit  = 1'b0;
    endcase
    return s;
  endfunction

  function automatic kind_t ident_kind(input logic [COL_BITS-1:0]    len,
                                       input logic [PREFIX_BITS-1:0] prefix);
    kind_t k;
    if (len == LEN_END && prefix == ID_END) k = K_END;
    else if (len == LEN_EDEF2 && prefix == ID_EDEF2) k = K_EDEF2;
    else if (len == LEN_DEF2 && prefix == ID_DEF2) k = K_DEF2;
    else if (len > COL_BITS'(1)) k = K_STRING;
    else k = K_CHAR;
    return k;
  endfunction

  function automatic res_t mk_res(input kind_t                kind,
                                  input logic [LINE_BITS-1:0] line,
                                  input logic [COL_BITS-1:0]  col,
                                  input logic [COL_BITS-1:0]  len,
                                  input logic                 err);
    res_t r;
    r.kind = kind;
    r.line = line;
    r.col  = col;
    r.len  = len;
    r.err  = err;
    r.last = 1'b0;
    return r;
  endfunction

endpackage

>>> design/proof_language_lexer.sv
// Channel  Direction  Payload
// s_*      in         tuser: cmd[1:0]; tdata: char_code[7:0]
// m_*      out        tuser: token_kind, error; tdata: line_index, column, length; tlast
//
// An item is taken into an input register, lexed from there when the result
// queue has room and its results written to that four-entry queue, which
// drives the m side. An item with one or no result is taken every cycle while
// the queue has room; an item with two results fills two entries, and the
// queue drains one result per cycle while m_tready is high.
// rst is synchronous; a restart command clears the lexer state with no result.
// Stalls on m_tready hold the queue; with three or more results queued the lexer waits
// and s_tready drops once the input register holds an item.
module proof_language_lexer import plx_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // char_code
  input  logic [S_USER_W-1:0] s_tuser,   // cmd
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // line_index, column, length
  output logic [M_USER_W-1:0] m_tuser,   // token_kind, error
  output logic                m_tlast
);

  logic                 in_valid;
  cmd_t                 in_cmd;
  logic [CHAR_BITS-1:0] in_char;
  logic                 space;
  logic                 fire;
  core_out_t            core_res;
  res_t                 head;

  assign fire     = in_valid && space;
  assign s_tready = !in_valid || space;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd  <= cmd_t'(s_tuser);
      in_char <= s_tdata;
    end
  end

  plx_core u_core (
    .clk       (clk),
    .rst       (rst),
    .en        (fire),
    .cmd       (in_cmd),
    .char_code (in_char),
    .result    (core_res)
  );

  plx_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (core_res),
    .space     (space),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (head)
  );

  assign m_tdata = M_DATA_W'({head.len, head.col, head.line});
  assign m_tuser = {head.err, head.kind};
  assign m_tlast = head.last;

endmodule

>>> design/plx_core.sv
`include "proof_language_lexer_defines.svh"

module plx_core import plx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  cmd_t                 cmd,
  input  logic [CHAR_BITS-1:0] char_code,
  output core_out_t            result
);

  pend_t                  pending, pending_next;
  logic                   block_comment, block_comment_next;
  logic                   line_comment, line_comment_next;
  logic                   halted, halted_next;
  logic [LINE_BITS-1:0]   line_counter, line_counter_next;
  logic [COL_BITS-1:0]    column_counter, column_counter_next;
  logic [COL_BITS-1:0]    token_start, token_start_next;
  logic [COL_BITS-1:0]    token_length, token_length_next;
  logic [PREFIX_BITS-1:0] ident_prefix, ident_prefix_next;

  logic  consumed;
  logic  rv, sv;
  res_t  r, s;
  sym_t  sym;
  logic  ident_char;

  assign sym        = symbol_lookup(char_code);
  assign ident_char = is_letter(char_code) || is_digit(char_code) ||
                      char_code == CH_UNDERSCORE;

  always_comb begin
    pending_next        = pending;
    block_comment_next  = block_comment;
    line_comment_next   = line_comment;
    halted_next         = halted;
    line_counter_next   = line_counter;
    column_counter_next = column_counter;
    token_start_next    = token_start;
    token_length_next   = token_length;
    ident_prefix_next   = ident_prefix;
    consumed            = 1'b0;
    rv                  = 1'b0;
    sv                  = 1'b0;
    r = mk_res(K_NEWLINE, line_counter, token_start, COL_BITS'(1), 1'b1);
    s = mk_res(K_NEWLINE, line_counter, column_counter, COL_BITS'(1), 1'b1);

    if (en) begin
      unique case (cmd)
        CMD_RESTART: begin
          pending_next        = P_NONE;
          block_comment_next  = 1'b0;
          line_comment_next   = 1'b0;
          halted_next         = 1'b0;
          line_counter_next   = '0;
          column_counter_next = '0;
          token_start_next    = '0;
          token_length_next   = '0;
          ident_prefix_next   = '0;
        end
        CMD_IGNORE: begin
        end
        CMD_CHAR: begin
          if (!halted) begin
            column_counter_next = sat_inc(column_counter);
            if (block_comment) begin
              if (pending == P_STAR && char_code == CH_SLASH) begin
                block_comment_next = 1'b0;
                pending_next       = P_NONE;
              end else begin
                pending_next = (char_code == CH_STAR) ? P_STAR : P_NONE;
              end
            end else if (!line_comment) begin
              // Settle the held token against this character.
              consumed     = 1'b1;
              pending_next = P_NONE;
              unique case (pending)
                P_SLASH: begin
                  if (char_code == CH_SLASH) begin
                    line_comment_next = 1'b1;
                  end else if (char_code == CH_STAR) begin
                    block_comment_next = 1'b1;
                    pending_next       = P_STAR;
                  end else begin
                    rv          = 1'b1;
                    halted_next = 1'b1;
                  end
                end
                P_COLON: begin
                  rv = 1'b1;
                  if (char_code == CH_EQ) begin
                    r = mk_res(K_DEFBY, line_counter, token_start, COL_BITS'(2), 1'b0);
                  end else begin
                    r = mk_res(K_COLON, line_counter, token_start, COL_BITS'(1), 1'b0);
                    consumed = 1'b0;
                  end
                end
                P_LT: begin
                  if (char_code == CH_MINUS) begin
                    pending_next = P_LT_MINUS;
                  end else if (char_code == CH_EQ) begin
                    pending_next = P_LT_EQ;
                  end else begin
                    rv          = 1'b1;
                    halted_next = 1'b1;
                  end
                end
                P_LT_MINUS: begin
                  rv = 1'b1;
                  if (char_code == CH_GT) begin
                    r = mk_res(K_LRARROW, line_counter, token_start, COL_BITS'(3), 1'b0);
                  end else begin
                    r = mk_res(K_LARROW, line_counter, token_start, COL_BITS'(2), 1'b0);
                    consumed = 1'b0;
                  end
                end
                P_LT_EQ: begin
                  rv = 1'b1;
                  if (char_code == CH_GT) begin
                    r = mk_res(K_LRDARROW, line_counter, token_start, COL_BITS'(3), 1'b0);
                  end else begin
                    r = mk_res(K_LDARROW, line_counter, token_start, COL_BITS'(2), 1'b0);
                    consumed = 1'b0;
                  end
                end
                P_MINUS: begin
                  rv = 1'b1;
                  if (char_code == CH_GT) begin
                    r = mk_res(K_RARROW, line_counter, token_start, COL_BITS'(2), 1'b0);
                  end else begin
                    r = mk_res(K_HYPHEN, line_counter, token_start, COL_BITS'(1), 1'b0);
                    consumed = 1'b0;
                  end
                end
                P_EQ: begin
                  rv = 1'b1;
                  if (char_code == CH_GT) begin
                    r = mk_res(K_RDARROW, line_counter, token_start, COL_BITS'(2), 1'b0);
                  end else begin
                    halted_next = 1'b1;
                  end
                end
                P_IDENT: begin
                  if (ident_char) begin
                    if (token_length < LEN_PREFIX) begin
                      ident_prefix_next = {ident_prefix[PREFIX_BITS-CHAR_BITS-1:0], char_code};
                    end
                    token_length_next = sat_inc(token_length);
                    pending_next      = P_IDENT;
                  end else begin
                    rv = 1'b1;
                    r  = mk_res(ident_kind(token_length, ident_prefix), line_counter,
                                token_start, token_length, 1'b0);
                    consumed = 1'b0;
                  end
                end
                P_NUMBER: begin
                  if (is_digit(char_code)) begin
                    token_length_next = sat_inc(token_length);
                    pending_next      = P_NUMBER;
                  end else begin
                    rv = 1'b1;
                    r  = mk_res(K_NUMBER, line_counter, token_start, token_length, 1'b0);
                    consumed = 1'b0;
                  end
                end
                default: consumed = 1'b0;
              endcase

              // Start a fresh token with this character.
              if (!consumed) begin
                token_start_next = column_counter;
                priority if (char_code == CH_SLASH) begin
                  pending_next = P_SLASH;
                end else if (char_code == CH_COLON) begin
                  pending_next = P_COLON;
                end else if (char_code == CH_LT) begin
                  pending_next = P_LT;
                end else if (char_code == CH_MINUS) begin
                  pending_next = P_MINUS;
                end else if (char_code == CH_EQ) begin
                  pending_next = P_EQ;
                end else if (is_letter(char_code)) begin
                  pending_next      = P_IDENT;
                  token_length_next = COL_BITS'(1);
                  ident_prefix_next = PREFIX_BITS'(char_code);
                end else if (is_digit(char_code)) begin
                  pending_next      = P_NUMBER;
                  token_length_next = COL_BITS'(1);
                end else if (char_code == CH_SPACE || char_code == CH_TAB) begin
                  pending_next = P_NONE;
                end else if (sym.hit) begin
                  sv = 1'b1;
                  s  = mk_res(sym.kind, line_counter, column_counter, COL_BITS'(1), 1'b0);
                end else begin
                  sv          = 1'b1;
                  halted_next = 1'b1;
                end
              end
            end
          end
        end
        CMD_EOL: begin
          if (!halted) begin
            if (!block_comment &&
                (pending == P_SLASH || pending == P_LT || pending == P_EQ)) begin
              // Incomplete operator at end of line: error, nothing else moves.
              rv           = 1'b1;
              halted_next  = 1'b1;
              pending_next = P_NONE;
            end else begin
              if (!block_comment) begin
                unique case (pending)
                  P_COLON: begin
                    rv = 1'b1;
                    r  = mk_res(K_COLON, line_counter, token_start, COL_BITS'(1), 1'b0);
                  end
                  P_LT_MINUS: begin
                    rv = 1'b1;
                    r  = mk_res(K_LARROW, line_counter, token_start, COL_BITS'(2), 1'b0);
                  end
                  P_LT_EQ: begin
                    rv = 1'b1;
                    r  = mk_res(K_LDARROW, line_counter, token_start, COL_BITS'(2), 1'b0);
                  end
                  P_MINUS: begin
                    rv = 1'b1;
                    r  = mk_res(K_HYPHEN, line_counter, token_start, COL_BITS'(1), 1'b0);
                  end
                  P_IDENT: begin
                    rv = 1'b1;
                    r  = mk_res(ident_kind(token_length, ident_prefix), line_counter,
                                token_start, token_length, 1'b0);
                  end
                  P_NUMBER: begin
                    rv = 1'b1;
                    r  = mk_res(K_NUMBER, line_counter, token_start, token_length, 1'b0);
                  end
                  default: rv = 1'b0;
                endcase
              end
              pending_next        = P_NONE;
              line_comment_next   = 1'b0;
              sv                  = 1'b1;
              s = mk_res(K_NEWLINE, line_counter, column_counter, '0, 1'b0);
              line_counter_next   = line_counter + LINE_BITS'(1);
              column_counter_next = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end

    result.first       = rv ? r : s;
    result.first.last  = !(rv && sv);
    result.second      = s;
    result.second.last = 1'b1;
    result.count       = {1'b0, rv} + {1'b0, sv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending        <= P_NONE;
      block_comment  <= 1'b0;
      line_comment   <= 1'b0;
      halted         <= 1'b0;
      line_counter   <= '0;
      column_counter <= '0;
      token_start    <= '0;
      token_length   <= '0;
      ident_prefix   <= '0;
    end else begin
      pending        <= pending_next;
      block_comment  <= block_comment_next;
      line_comment   <= line_comment_next;
      halted         <= halted_next;
      line_counter   <= line_counter_next;
      column_counter <= column_counter_next;
      token_start    <= token_start_next;
      token_length   <= token_length_next;
      ident_prefix   <= ident_prefix_next;
    end
  end

  `PLX_ASSERT_IMPLIES(a_halt_quiet, clk, rst, en && halted && cmd != CMD_RESTART, result.count == 2'd0)
  `PLX_ASSERT_NEXT(a_error_halts, clk, rst, en && ((rv && r.err) || (sv && s.err)), halted)
  `PLX_ASSERT_IMPLIES(a_block_pending, clk, rst, block_comment, pending == P_NONE || pending == P_STAR)
  `PLX_ASSERT_IMPLIES(a_star_in_block, clk, rst, pending == P_STAR, block_comment)

endmodule

>>> design/plx_fifo.sv
`include "proof_language_lexer_defines.svh"

module plx_fifo import plx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  core_out_t  push,
  output logic       space,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       out_data
);

  res_t                mem [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                pop;

  assign out_valid = count != '0;
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  // Room for the two results an item may cause.
  assign space     = count <= CNT_BITS'(FIFO_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_BITS'(push.count);
      rd_ptr <= rd_ptr + PTR_BITS'(pop);
      count  <= count + CNT_BITS'(push.count) - CNT_BITS'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + PTR_BITS'(1)] <= push.second;
    end
  end

  `PLX_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_BITS'(FIFO_DEPTH))
  `PLX_ASSERT_IMPLIES(a_no_overflow, clk, rst, push.count != 2'd0, count <= CNT_BITS'(FIFO_DEPTH - 2))

endmodule

>>> tb/tb_proof_language_lexer.sv
module tb_proof_language_lexer import plx_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int RANDOM_ITEMS = 1700;

  class lexer_scoreboard;
    res_t                   tokens_due[$];
    pend_t                  pend;
    bit                     in_block;
    bit                     in_line;
    bit                     halted;
    logic [LINE_BITS-1:0]   line_no;
    logic [COL_BITS-1:0]    col_no;
    logic [COL_BITS-1:0]    tok_start;
    logic [COL_BITS-1:0]    tok_len;
    logic [PREFIX_BITS-1:0] prefix;
    int                     failures;
    int                     item_count;

    function new();
      clear_state();
      failures   = 0;
      item_count = 0;
    endfunction

    function void clear_state();
      pend      = P_NONE;
      in_block  = 1'b0;
      in_line   = 1'b0;
      halted    = 1'b0;
      line_no   = '0;
      col_no    = '0;
      tok_start = '0;
      tok_len   = '0;
      prefix    = '0;
    endfunction

    function bit busy();
      return tokens_due.size() != 0;
    endfunction

    function logic [COL_BITS-1:0] col_step(input logic [COL_BITS-1:0] v);
      return (v == COL_MAX) ? v : v + 1'b1;
    endfunction

    function bit letter(input logic [CHAR_BITS-1:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit digit(input logic [CHAR_BITS-1:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit single_kind(input logic [CHAR_BITS-1:0] c, output kind_t k);
      bit hit;
      hit = 1'b1;
      k   = K_NEWLINE;
      unique case (c)
        "(": k = K_LPAREN;
        ")": k = K_RPAREN;
        "[": k = K_LBRACKET;
        "]": k = K_RBRACKET;
        "{": k = K_LBRACE;
        "}": k = K_RBRACE;
        "$": k = K_DOLLAR;
        "?": k = K_QUESTION;
        "@": k = K_AT;
        "*": k = K_ASTERISK;
        ":": k = K_COLON;
        ".": k = K_PERIOD;
        ",": k = K_COMMA;
        "\\": k = K_BACKSLASH;
        ";": k = K_SEMICOLON;
        "#": k = K_HASH;
        "%": k = K_PERCENT;
        "|": k = K_VBAR;
        "_": k = K_UNDERSCORE;
        "-": k = K_HYPHEN;
        default: hit = 1'b0;
      endcase
      return hit;
    endfunction

    function kind_t word_kind();
      if (tok_len == LEN_END && prefix == ID_END) return K_END;
      if (tok_len == LEN_EDEF2 && prefix == ID_EDEF2) return K_EDEF2;
      if (tok_len == LEN_DEF2 && prefix == ID_DEF2) return K_DEF2;
      return (tok_len > 1) ? K_STRING : K_CHAR;
    endfunction

    function void push_token(input kind_t kind, input logic [COL_BITS-1:0] pos,
                             input logic [COL_BITS-1:0] len, input logic err);
      res_t t;
      t.kind = kind;
      t.line = line_no;
      t.col  = pos;
      t.len  = len;
      t.err  = err;
      t.last = 1'b0;
      tokens_due.insert(tokens_due.size(), t);
    endfunction

    // Error token, then nothing until restart.
    function void halt_at(input logic [COL_BITS-1:0] pos);
      push_token(K_NEWLINE, pos, COL_BITS'(1), 1'b1);
      halted = 1'b1;
      pend   = P_NONE;
    endfunction

    function void start_token(input logic [CHAR_BITS-1:0] c, input logic [COL_BITS-1:0] pos);
      kind_t k;
      tok_start = pos;
      if (c == CH_SLASH) pend = P_SLASH;
      else if (c == CH_COLON) pend = P_COLON;
      else if (c == CH_LT) pend = P_LT;
      else if (c == CH_MINUS) pend = P_MINUS;
      else if (c == CH_EQ) pend = P_EQ;
      else if (letter(c)) begin
        pend    = P_IDENT;
        tok_len = COL_BITS'(1);
        prefix  = PREFIX_BITS'(c);
      end else if (digit(c)) begin
        pend    = P_NUMBER;
        tok_len = COL_BITS'(1);
      end else if (c == CH_SPACE || c == CH_TAB) begin
      end else if (single_kind(c, k)) push_token(k, pos, COL_BITS'(1), 1'b0);
      else halt_at(pos);
    endfunction

    // Settle the held token with c; returns 1 when c is consumed.
    function bit resolve(input logic [CHAR_BITS-1:0] c);
      pend_t was;
      was = pend;
      if (was == P_NONE) return 1'b0;
      pend = P_NONE;
      case (was)
        P_SLASH: begin
          if (c == CH_SLASH) in_line = 1'b1;
          else if (c == CH_STAR) begin
            in_block = 1'b1;
            pend     = P_STAR;
          end else halt_at(tok_start);
          return 1'b1;
        end
        P_COLON: begin
          if (c == CH_EQ) begin
            push_token(K_DEFBY, tok_start, COL_BITS'(2), 1'b0);
            return 1'b1;
          end
          push_token(K_COLON, tok_start, COL_BITS'(1), 1'b0);
          return 1'b0;
        end
        P_LT: begin
          if (c == CH_MINUS) pend = P_LT_MINUS;
          else if (c == CH_EQ) pend = P_LT_EQ;
          else halt_at(tok_start);
          return 1'b1;
        end
        P_LT_MINUS: begin
          if (c == CH_GT) begin
            push_token(K_LRARROW, tok_start, COL_BITS'(3), 1'b0);
            return 1'b1;
          end
          push_token(K_LARROW, tok_start, COL_BITS'(2), 1'b0);
          return 1'b0;
        end
        P_LT_EQ: begin
          if (c == CH_GT) begin
            push_token(K_LRDARROW, tok_start, COL_BITS'(3), 1'b0);
            return 1'b1;
          end
          push_token(K_LDARROW, tok_start, COL_BITS'(2), 1'b0);
          return 1'b0;
        end
        P_MINUS: begin
          if (c == CH_GT) begin
            push_token(K_RARROW, tok_start, COL_BITS'(2), 1'b0);
            return 1'b1;
          end
          push_token(K_HYPHEN, tok_start, COL_BITS'(1), 1'b0);
          return 1'b0;
        end
        P_EQ: begin
          if (c == CH_GT) push_token(K_RDARROW, tok_start, COL_BITS'(2), 1'b0);
          else halt_at(tok_start);
          return 1'b1;
        end
        P_IDENT: begin
          if (letter(c) || digit(c) || c == CH_UNDERSCORE) begin
            if (tok_len < LEN_PREFIX) prefix = {prefix[PREFIX_BITS-CHAR_BITS-1:0], c};
            tok_len = col_step(tok_len);
            pend    = P_IDENT;
            return 1'b1;
          end
          push_token(word_kind(), tok_start, tok_len, 1'b0);
          return 1'b0;
        end
        P_NUMBER: begin
          if (digit(c)) begin
            tok_len = col_step(tok_len);
            pend    = P_NUMBER;
            return 1'b1;
          end
          push_token(K_NUMBER, tok_start, tok_len, 1'b0);
          return 1'b0;
        end
        default: return 1'b0;
      endcase
    endfunction

    function void take_char(input logic [CHAR_BITS-1:0] c);
      logic [COL_BITS-1:0] pos;
      pos = col_no;
      if (in_block) begin
        if (pend == P_STAR && c == CH_SLASH) begin
          in_block = 1'b0;
          pend     = P_NONE;
        end else pend = (c == CH_STAR) ? P_STAR : P_NONE;
      end else if (!in_line) begin
        if (!resolve(c)) start_token(c, pos);
      end
      col_no = col_step(pos);
    endfunction

    function void take_eol();
      if (in_block) pend = P_NONE;
      else begin
        case (pend)
          P_SLASH, P_LT, P_EQ: begin
            halt_at(tok_start);
            return;
          end
          P_COLON:    push_token(K_COLON, tok_start, COL_BITS'(1), 1'b0);
          P_LT_MINUS: push_token(K_LARROW, tok_start, COL_BITS'(2), 1'b0);
          P_LT_EQ:    push_token(K_LDARROW, tok_start, COL_BITS'(2), 1'b0);
          P_MINUS:    push_token(K_HYPHEN, tok_start, COL_BITS'(1), 1'b0);
          P_IDENT:    push_token(word_kind(), tok_start, tok_len, 1'b0);
          P_NUMBER:   push_token(K_NUMBER, tok_start, tok_len, 1'b0);
          default: begin
          end
        endcase
      end
      pend    = P_NONE;
      in_line = 1'b0;
      push_token(K_NEWLINE, col_no, '0, 1'b0);
      line_no = line_no + 1'b1;
      col_no  = '0;
    endfunction

    // Returns 1 when the item has any effect on the lexer.
    function bit note_item(input cmd_t cmd, input logic [CHAR_BITS-1:0] c);
      int depth;
      if (cmd == CMD_RESTART) begin
        clear_state();
        return 1'b1;
      end
      if (cmd == CMD_IGNORE || halted) return 1'b0;
      item_count++;
      depth = tokens_due.size();
      if (cmd == CMD_CHAR) take_char(c);
      else take_eol();
      if (tokens_due.size() > depth) tokens_due[tokens_due.size() - 1].last = 1'b1;
      return 1'b1;
    endfunction

    function void compare(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_token(input res_t got);
      res_t want;
      if (tokens_due.size() == 0) begin
        $error("token_kind: expected none, got %0d (line %0d, column %0d)",
               got.kind, got.line, got.col);
        failures++;
        return;
      end
      want = tokens_due.pop_front();
      compare("token_kind", 32'(want.kind), 32'(got.kind));
      compare("line_index", 32'(want.line), 32'(got.line));
      compare("column", 32'(want.col), 32'(got.col));
      compare("length", 32'(want.len), 32'(got.len));
      compare("error", 32'(want.err), 32'(got.err));
      compare("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic [S_USER_W-1:0] s_tuser  = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [M_USER_W-1:0] m_tuser;
  logic                m_tlast;

  lexer_scoreboard sb = new();

  int burst_left     = 0;
  int lexed_items    = 0;
  int hold_left      = 0;
  int quiet_phase    = 0;
  bit long_hold_done = 1'b0;
  int cycle_count    = 0;

  string keyword_words[12] = '{"END", "def2", "edef2", "EN", "ENDD", "def", "edef",
                               "def23", "edef2x", "end", "Edef2", "E"};
  string op_words[11] = '{":=", "->", "=>", "<-", "<->", "<=", "<=>", ":", "-",
                          ":-", "-->"};
  string symbol_chars = "()[]{}$?@*:.,\\;#%|_-";

  proof_language_lexer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: check accepted tokens, stall on a pattern with quiet stretches.
  always @(posedge clk) begin : result_side
    res_t got;
    bit   ready_next;
    if (!rst && m_tvalid && m_tready) begin
      got.kind = kind_t'(m_tuser[KIND_BITS-1:0]);
      got.err  = m_tuser[KIND_BITS];
      got.line = m_tdata[LINE_BITS-1:0];
      got.col  = m_tdata[LINE_BITS +: COL_BITS];
      got.len  = m_tdata[LINE_BITS+COL_BITS +: COL_BITS];
      got.last = m_tlast;
      sb.check_token(got);
    end
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      ready_next = 1'b0;
    end else if (!long_hold_done && sb.item_count >= 400) begin
      // long hold-off: fill the result queue and back up the input side
      hold_left      = 200;
      long_hold_done = 1'b1;
      ready_next     = 1'b0;
    end else begin
      quiet_phase = (quiet_phase + 1) % 256;
      ready_next  = (quiet_phase < 64) || ($urandom_range(0, 3) != 0);
    end
    m_tready <= ready_next;
  end

  task automatic send_item(input cmd_t cmd, input logic [CHAR_BITS-1:0] c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
    void'(sb.note_item(cmd, c));
    lexed_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(CMD_CHAR, s[i]);
  endtask

  task automatic send_eol();
    send_item(CMD_EOL, 8'($urandom));
  endtask

  task automatic send_restart();
    send_item(CMD_RESTART, 8'($urandom));
  endtask

  // Hold the input until every expected token has come out.
  task automatic drain_wait();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.busy());
  endtask

  function automatic logic [CHAR_BITS-1:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [CHAR_BITS-1:0] rand_word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 52) return rand_letter();
    if (r < 62) return 8'("0" + r - 52);
    return CH_UNDERSCORE;
  endfunction

  function automatic logic [CHAR_BITS-1:0] rand_print();
    return 8'($urandom_range(32, 126));
  endfunction

  // One line of mostly well-formed tokens, with some noise, then end of line.
  task automatic random_line();
    int n;
    int pick;
    n = $urandom_range(0, 8);
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        send_item(CMD_CHAR, rand_letter());
        repeat ($urandom_range(0, 7)) send_item(CMD_CHAR, rand_word_char());
      end else if (pick < 33) begin
        send_text(keyword_words[$urandom_range(0, 11)]);
        if ($urandom_range(0, 1)) send_item(CMD_CHAR, CH_SPACE);
      end else if (pick < 42) begin
        repeat ($urandom_range(1, 6)) send_item(CMD_CHAR, 8'("0" + $urandom_range(0, 9)));
      end else if (pick < 56) begin
        send_text(op_words[$urandom_range(0, 10)]);
      end else if (pick < 70) begin
        send_item(CMD_CHAR, symbol_chars[$urandom_range(0, symbol_chars.len() - 1)]);
      end else if (pick < 82) begin
        repeat ($urandom_range(1, 3)) send_item(CMD_CHAR, $urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      end else if (pick < 87) begin
        send_text("//");
        repeat ($urandom_range(0, 10)) send_item(CMD_CHAR, rand_print());
      end else if (pick < 93) begin
        if ($urandom_range(0, 4) == 0) send_text("/*/");
        else send_text("/*");
        repeat ($urandom_range(0, 6))
          send_item(CMD_CHAR, ($urandom_range(0, 2) == 0) ? CH_STAR : rand_print());
        if ($urandom_range(0, 4) != 0) send_text("*/");
      end else if (pick < 98) begin
        send_item(CMD_CHAR, 8'($urandom_range(0, 255)));
      end else if (pick == 98) begin
        send_item(CMD_IGNORE, 8'($urandom));
      end else begin
        send_restart();
      end
    end
    send_eol();
    if (sb.halted && $urandom_range(0, 4) != 0) send_restart();
  endtask

  initial begin
    int pause_mark;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // slash-star-slash is a whole comment
    send_text("/*/x");
    send_eol();
    // star before end of line keeps the comment open
    send_text("/*");
    send_eol();
    send_text("*");
    send_eol();
    send_text("*/a");
    send_eol();
    send_item(CMD_IGNORE, 8'hA5);
    // unknown bytes halt the lexer until restart
    send_item(CMD_CHAR, 8'h00);
    send_text("a");
    send_eol();
    send_restart();
    send_item(CMD_CHAR, 8'hFF);
    send_restart();
    send_text("x<y");
    send_restart();
    drain_wait();

    lexed_items = 0;
    pause_mark  = 300;
    while (lexed_items < RANDOM_ITEMS) begin
      random_line();
      if (lexed_items >= pause_mark) begin
        drain_wait();
        pause_mark += 300;
      end
    end

    drain_wait();
    repeat (10) @(posedge clk);
    if (sb.failures == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> proof_language_lexer.f
+incdir+design
design/plx_pkg.sv
design/plx_core.sv
design/plx_fifo.sv
design/proof_language_lexer.sv
tb/tb_proof_language_lexer.sv
